FILE: rtl/waveform_peak_decimator_core_assert.svh
// Assertion macros used by the checker of this block.
`ifndef WAVEFORM_PEAK_DECIMATOR_CORE_ASSERT_SVH
`define WAVEFORM_PEAK_DECIMATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WPD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/wpd_pkg.sv
package wpd_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int MAX_BUCKETS    = 4096;
    localparam int TOTAL_BITS     = 32;
    localparam int COUNT_BITS     = 13;
    localparam int INDEX_BITS     = 12;
    localparam int REM_BITS       = 12;
    localparam int CHAN_BITS      = 2;
    localparam int PEAK_MAX_BITS  = 23;
    localparam int CFG_INDEX_BITS = 2;
    localparam int IN_DATA_BITS   = 48;
    localparam int OUT_DATA_BITS  = 72;

    localparam logic [TOTAL_BITS-1:0] TOTAL_RESET   = TOTAL_BITS'(1);
    localparam logic [COUNT_BITS-1:0] BUCKETS_RESET = COUNT_BITS'(MAX_BUCKETS);
    localparam logic [CHAN_BITS-1:0]  CHAN_RESET    = CHAN_BITS'(2);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_TOTAL_FRAMES  = 2'd0,
        CFG_BUCKET_COUNT  = 2'd1,
        CFG_CHANNEL_COUNT = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] max_val;
        logic [SAMPLE_BITS-1:0] min_val;
    } peak_t;

    typedef struct packed {
        logic [TOTAL_BITS-1:0] quot;
        logic [REM_BITS-1:0]   rem;
    } div_res_t;

    typedef struct packed {
        logic step;
        logic close_last;
        logic frame_inc;
        logic emit;
    } ctrl_t;

endpackage

FILE: rtl/waveform_peak_decimator_core.sv
// Min/max peak decimator for a waveform display.
// s_axis carries one audio frame per word: left sample in tdata[23:0], right
// sample in tdata[47:24], both signed Q1.23. m_axis carries one word for each
// frame that closes one or more display buckets; tlast marks the final bucket.
// cfg_valid/cfg_ready/cfg_index/cfg_data write the total frame count, the
// bucket count and the channel count; a write to any of the three restarts the pass.
// An accepted frame is folded into the left sample lane, and into the right
// lane too when the channel count is 2 or 3; the bucket sequencer then steps
// through each bucket that the frame closes and finishes by returning to
// idle or by moving to the emit state. No new frame is accepted until the
// sequencer is back in idle. Results sit in an output register, so the next
// frame is accepted while a result waits; a stalled receiver holds the block
// only when a second result is ready behind the first.
// After reset and after each configuration write, a 32-step divider works out
// the bucket step from the two counts; s_axis_tready stays low meanwhile.
module waveform_peak_decimator_core
    import wpd_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // sample_left, sample_right
    input  logic [IN_DATA_BITS-1:0]   s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // first_bucket, bucket_span, peak_max, peak_min
    output logic [OUT_DATA_BITS-1:0]  m_axis_tdata,
    output logic                      m_axis_tlast,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [TOTAL_BITS-1:0]     cfg_data
);

    logic [TOTAL_BITS-1:0]    total_reg;
    logic [COUNT_BITS-1:0]    buckets_reg;
    logic [CHAN_BITS-1:0]     chans_reg;
    logic                     restart_reg;
    state_t                   state_reg;
    state_t                   state_next;
    logic [TOTAL_BITS-1:0]    frame_reg;
    logic [COUNT_BITS-1:0]    bucket_reg;
    logic [TOTAL_BITS-1:0]    eff_end_reg;
    logic [TOTAL_BITS-1:0]    raw_end_reg;
    logic [REM_BITS-1:0]      rem_reg;
    logic [COUNT_BITS-1:0]    span_reg;
    logic [INDEX_BITS-1:0]    first_reg;
    logic                     last_reg;
    logic                     m_valid_reg;
    logic [INDEX_BITS-1:0]    out_first_reg;
    logic [COUNT_BITS-1:0]    out_span_reg;
    logic [PEAK_MAX_BITS-1:0] out_max_reg;
    logic [SAMPLE_BITS-1:0]   out_min_reg;
    logic                     out_last_reg;

    logic [TOTAL_BITS-1:0]    total_eff;
    logic [COUNT_BITS-1:0]    n_eff;
    logic                     cfg_write;
    logic                     s_fire;
    logic                     out_free;
    logic                     close;
    logic                     last_bkt;
    logic                     div_busy;
    logic                     div_done;
    logic                     div_start;
    div_res_t                 div_res;
    logic [TOTAL_BITS-1:0]    first_end;
    logic [COUNT_BITS-1:0]    rem_sum;
    logic                     carry;
    logic [TOTAL_BITS-1:0]    raw_adv;
    logic [TOTAL_BITS-1:0]    eff_adv;
    logic [REM_BITS-1:0]      rem_adv;
    ctrl_t                    ctrl;
    peak_t                    left_peaks;
    peak_t                    right_peaks;
    peak_t                    merged;

    assign total_eff = (total_reg == '0) ? TOTAL_BITS'(1) : total_reg;

    always_comb begin
        if (buckets_reg == '0) begin
            n_eff = COUNT_BITS'(1);
        end else if (buckets_reg > COUNT_BITS'(MAX_BUCKETS)) begin
            n_eff = COUNT_BITS'(MAX_BUCKETS);
        end else begin
            n_eff = buckets_reg;
        end
    end

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready
        && (cfg_index == CFG_TOTAL_FRAMES || cfg_index == CFG_BUCKET_COUNT
            || cfg_index == CFG_CHANNEL_COUNT);

    assign s_axis_tready = (state_reg == ST_IDLE) && !restart_reg && !div_busy;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    assign close    = {1'b0, eff_end_reg} <= ({1'b0, frame_reg} + (TOTAL_BITS + 1)'(1));
    assign last_bkt = ({1'b0, bucket_reg} + (COUNT_BITS + 1)'(1)) >= {1'b0, n_eff};

    // Bucket b+1 ends at floor(T*(b+2)/N); step by T/N with the remainder carried.
    assign first_end = (div_res.quot != '0) ? div_res.quot : TOTAL_BITS'(1);
    assign rem_sum   = {1'b0, rem_reg} + {1'b0, div_res.rem};
    assign carry     = rem_sum >= n_eff;
    assign rem_adv   = carry ? REM_BITS'(rem_sum - n_eff) : rem_sum[REM_BITS-1:0];
    assign raw_adv   = raw_end_reg + div_res.quot + TOTAL_BITS'(carry);
    assign eff_adv   = (div_res.quot != '0 || carry) ? raw_adv
                                                     : raw_end_reg + TOTAL_BITS'(1);

    assign div_start = restart_reg && !div_busy;

    wpd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (total_eff),
        .divisor  (n_eff),
        .busy     (div_busy),
        .done     (div_done),
        .res      (div_res)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (close && last_bkt) begin
                    state_next = ST_EMIT;
                end else if (!close) begin
                    state_next = (span_reg == '0) ? ST_IDLE : ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        ctrl = '0;
        case (state_reg)
            ST_SCAN: begin
                ctrl.step       = close && !last_bkt;
                ctrl.close_last = close && last_bkt;
                ctrl.frame_inc  = !close;
            end
            ST_EMIT: begin
                ctrl.emit = out_free;
            end
            default: begin
                ctrl = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg   <= TOTAL_RESET;
            buckets_reg <= BUCKETS_RESET;
            chans_reg   <= CHAN_RESET;
        end else if (cfg_write) begin
            case (cfg_index_t'(cfg_index))
                CFG_TOTAL_FRAMES:  total_reg   <= cfg_data;
                CFG_BUCKET_COUNT:  buckets_reg <= cfg_data[COUNT_BITS-1:0];
                CFG_CHANNEL_COUNT: chans_reg   <= cfg_data[CHAN_BITS-1:0];
                default: begin
                    total_reg <= total_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            restart_reg <= 1'b1;
            frame_reg   <= '0;
            bucket_reg  <= '0;
            eff_end_reg <= TOTAL_BITS'(1);
            raw_end_reg <= '0;
            rem_reg     <= '0;
            span_reg    <= '0;
            first_reg   <= '0;
            last_reg    <= 1'b0;
        end else if (cfg_write) begin
            restart_reg <= 1'b1;
            frame_reg   <= '0;
            bucket_reg  <= '0;
            span_reg    <= '0;
            last_reg    <= 1'b0;
        end else begin
            if (div_start) begin
                restart_reg <= 1'b0;
            end
            if (div_done) begin
                raw_end_reg <= div_res.quot;
                eff_end_reg <= first_end;
                rem_reg     <= div_res.rem;
            end
            if (s_fire) begin
                first_reg <= bucket_reg[INDEX_BITS-1:0];
                span_reg  <= '0;
            end
            if (ctrl.step) begin
                span_reg    <= span_reg + COUNT_BITS'(1);
                bucket_reg  <= bucket_reg + COUNT_BITS'(1);
                raw_end_reg <= raw_adv;
                eff_end_reg <= eff_adv;
                rem_reg     <= rem_adv;
            end
            if (ctrl.close_last) begin
                span_reg <= span_reg + COUNT_BITS'(1);
                last_reg <= 1'b1;
            end
            if (ctrl.frame_inc) begin
                frame_reg <= frame_reg + TOTAL_BITS'(1);
            end
            if (ctrl.emit) begin
                span_reg <= '0;
                last_reg <= 1'b0;
                if (last_reg) begin
                    frame_reg   <= '0;
                    bucket_reg  <= '0;
                    raw_end_reg <= div_res.quot;
                    eff_end_reg <= first_end;
                    rem_reg     <= div_res.rem;
                end
            end
        end
    end

    wpd_lane u_lane_left (
        .aclk    (aclk),
        .aresetn (aresetn),
        .sample  (s_axis_tdata[SAMPLE_BITS-1:0]),
        .fold_en (s_fire),
        .clear   (ctrl.emit || cfg_write),
        .peaks   (left_peaks)
    );

    wpd_lane u_lane_right (
        .aclk    (aclk),
        .aresetn (aresetn),
        .sample  (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .fold_en (s_fire && chans_reg[1]),
        .clear   (ctrl.emit || cfg_write),
        .peaks   (right_peaks)
    );

    wpd_merge u_merge (
        .left_peaks  (left_peaks),
        .right_peaks (right_peaks),
        .merged      (merged)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.emit) begin
            out_first_reg <= first_reg;
            out_span_reg  <= span_reg;
            out_max_reg   <= merged.max_val[PEAK_MAX_BITS-1:0];
            out_min_reg   <= merged.min_val;
            out_last_reg  <= last_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {out_min_reg, out_max_reg, out_span_reg, out_first_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

FILE: rtl/wpd_lane.sv
module wpd_lane
    import wpd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic                   fold_en,
    input  logic                   clear,
    output peak_t                  peaks
);

    logic [SAMPLE_BITS-1:0] max_reg;
    logic [SAMPLE_BITS-1:0] min_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            max_reg <= '0;
            min_reg <= '0;
        end else if (fold_en) begin
            if ($signed(sample) > $signed(max_reg)) begin
                max_reg <= sample;
            end
            if ($signed(sample) < $signed(min_reg)) begin
                min_reg <= sample;
            end
        end
    end

    assign peaks.max_val = max_reg;
    assign peaks.min_val = min_reg;

endmodule

FILE: rtl/wpd_merge.sv
module wpd_merge
    import wpd_pkg::*;
(
    input  peak_t left_peaks,
    input  peak_t right_peaks,
    output peak_t merged
);

    always_comb begin
        if ($signed(right_peaks.max_val) > $signed(left_peaks.max_val)) begin
            merged.max_val = right_peaks.max_val;
        end else begin
            merged.max_val = left_peaks.max_val;
        end
        if ($signed(right_peaks.min_val) < $signed(left_peaks.min_val)) begin
            merged.min_val = right_peaks.min_val;
        end else begin
            merged.min_val = left_peaks.min_val;
        end
    end

endmodule

FILE: rtl/wpd_div.sv
module wpd_div
    import wpd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [TOTAL_BITS-1:0] dividend,
    input  logic [COUNT_BITS-1:0] divisor,
    output logic                  busy,
    output logic                  done,
    output div_res_t              res
);

    localparam int STEP_BITS = $clog2(TOTAL_BITS);

    logic                  busy_reg;
    logic                  done_reg;
    logic [STEP_BITS-1:0]  cnt_reg;
    logic [TOTAL_BITS-1:0] quot_reg;
    logic [COUNT_BITS-1:0] part_reg;
    logic [COUNT_BITS-1:0] divisor_reg;
    logic [COUNT_BITS:0]   shifted;
    logic [COUNT_BITS:0]   diff;
    logic                  fits;

    assign shifted = {part_reg, quot_reg[TOTAL_BITS-1]};
    assign fits    = shifted >= {1'b0, divisor_reg};
    assign diff    = shifted - {1'b0, divisor_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + STEP_BITS'(1);
                if (cnt_reg == STEP_BITS'(TOTAL_BITS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            quot_reg    <= dividend;
            part_reg    <= '0;
            divisor_reg <= divisor;
        end else if (busy_reg) begin
            quot_reg <= {quot_reg[TOTAL_BITS-2:0], fits};
            part_reg <= fits ? diff[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign res.quot = quot_reg;
    assign res.rem  = part_reg[REM_BITS-1:0];

endmodule

FILE: rtl/wpd_checker.sv
`include "waveform_peak_decimator_core_assert.svh"

module wpd_checker
    import wpd_pkg::*;
(
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_axis_tvalid,
    input logic                      s_axis_tready,
    input logic [IN_DATA_BITS-1:0]   s_axis_tdata,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [OUT_DATA_BITS-1:0]  m_axis_tdata,
    input logic                      m_axis_tlast,
    input logic                      cfg_valid,
    input logic                      cfg_ready,
    input logic [CFG_INDEX_BITS-1:0] cfg_index,
    input logic [TOTAL_BITS-1:0]     cfg_data
);

    `WPD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result word changed while stalled")
    `WPD_ASSERT_NOW(a_span_nonzero, m_axis_tvalid, m_axis_tdata[24:12] != 13'd0, "result word with zero bucket span")
    `WPD_ASSERT_NOW(a_min_nonpositive, m_axis_tvalid, m_axis_tdata[71] || m_axis_tdata[71:48] == 24'd0, "positive minimum peak")
    `WPD_ASSERT_NEXT(a_cfg_restart, cfg_valid && cfg_ready && (cfg_index == CFG_TOTAL_FRAMES || cfg_index == CFG_BUCKET_COUNT || cfg_index == CFG_CHANNEL_COUNT), !s_axis_tready, "frame accepted during restart after a register write")

endmodule

bind waveform_peak_decimator_core wpd_checker u_wpd_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
);
